@@ src/fmg_pkg.sv @@
// shared types and constants for the framed message generator
package fmg_pkg;

    localparam int CMD_W       = 8;
    localparam int PAYLOAD_W   = 64;
    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int SEQ_W       = 8;
    localparam int POS_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_DATA_W   = CMD_W + PAYLOAD_W;

    localparam logic [BYTE_W-1:0] FRAME_OPEN  = 8'h3C;
    localparam logic [BYTE_W-1:0] FRAME_CLOSE = 8'h3E;
    localparam logic [SEQ_W-1:0]  COUNT_SKIP  = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_OPEN    = 4'd0;
    localparam logic [POS_W-1:0] POS_SEQ     = 4'd1;
    localparam logic [POS_W-1:0] POS_CMD     = 4'd2;
    localparam logic [POS_W-1:0] POS_PAY0    = 4'd3;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd11;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd12;
    localparam logic [POS_W-1:0] POS_CLOSE   = 4'd13;

    typedef struct packed {
        logic [SEQ_W-1:0]     seq;
        logic [CMD_W-1:0]     cmd;
        logic [PAYLOAD_W-1:0] payload;
        logic [CRC_W-1:0]     crc;
    } fmg_entry_t;

endpackage

@@ src/fmg_front.sv @@
// front end: accepts requests, assigns the sequence number, runs the crc a byte per cycle
module fmg_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fmg_pkg::CMD_W-1:0]       in_cmd,
    input  logic [fmg_pkg::PAYLOAD_W-1:0]   in_payload,
    output logic                            push,
    output fmg_pkg::fmg_entry_t             push_entry,
    input  logic                            queue_full
);
    import fmg_pkg::*;

    localparam int STEP_W = $clog2(BYTE_W) + 1;
    localparam int SPAN_W = BYTE_W * 8;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SEQ_W-1:0]      count_reg, count_next;
    logic [CRC_W-1:0]      crc_reg, crc_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [PAYLOAD_W-1:0]  payload_reg, payload_next;
    logic                  accept;
    logic                  crc_done;
    logic [SEQ_W-1:0]      seq_use;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign crc_done = step_reg[STEP_W-1];
    assign push     = busy_reg && crc_done && !queue_full;
    assign seq_use  = (count_reg == COUNT_SKIP) ? '0 : count_reg;

    assign push_entry.seq     = seq_reg;
    assign push_entry.cmd     = cmd_reg;
    assign push_entry.payload = payload_reg;
    assign push_entry.crc     = crc_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        span_next    = span_reg;
        seq_next     = seq_reg;
        cmd_next     = cmd_reg;
        payload_next = payload_reg;
        if (accept)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            count_next   = seq_use + 1'b1;
            crc_next     = CRC_INIT;
            span_next    = {in_payload[SPAN_W-CMD_W-SEQ_W-1:0], in_cmd, seq_use};
            seq_next     = seq_use;
            cmd_next     = in_cmd;
            payload_next = in_payload;
        end
        else if (busy_reg && !crc_done)
        begin
            crc_next  = crc_byte(crc_reg, span_reg[BYTE_W-1:0]);
            span_next = span_reg >> BYTE_W;
            step_next = step_reg + 1'b1;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        span_reg    <= span_next;
        seq_reg     <= seq_next;
        cmd_reg     <= cmd_next;
        payload_reg <= payload_next;
    end

`ifndef SYNTH
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(BYTE_W))
        else $error("crc step counter out of range");
    a_push_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !busy_reg)
        else $error("front still busy after push");
    a_seq_never_skip: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_entry.seq != COUNT_SKIP)
        else $error("reserved sequence value sent");
`endif
endmodule

@@ src/fmg_queue.sv @@
// short queue between the front and back ends
module fmg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fmg_pkg::fmg_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output fmg_pkg::fmg_entry_t head_entry
);
    import fmg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    fmg_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif
endmodule

@@ src/fmg_back.sv @@
// back end: walks one queued frame out a byte per cycle while out_ready is not held low, through an output register
module fmg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  fmg_pkg::fmg_entry_t         head_entry,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fmg_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last
);
    import fmg_pkg::*;

    localparam int PIDX_W = $clog2(PAYLOAD_W / BYTE_W);

    fmg_entry_t           entry_reg, entry_next;
    logic                 active_reg, active_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 advance;
    logic                 emit;
    logic                 at_close;
    logic [PIDX_W-1:0]    pay_idx;
    logic [BYTE_W-1:0]    cur_byte;

    assign advance  = !out_valid_reg || out_ready;
    assign emit     = advance && active_reg;
    assign at_close = (pos_reg == POS_CLOSE);
    assign pop      = head_valid && (!active_reg || (emit && at_close));
    assign pay_idx  = PIDX_W'(pos_reg - POS_PAY0);

    always_comb
    begin
        unique case (pos_reg)
            POS_OPEN:   cur_byte = FRAME_OPEN;
            POS_SEQ:    cur_byte = entry_reg.seq;
            POS_CMD:    cur_byte = entry_reg.cmd;
            POS_CRC_LO: cur_byte = entry_reg.crc[BYTE_W-1:0];
            POS_CRC_HI: cur_byte = entry_reg.crc[CRC_W-1:BYTE_W];
            POS_CLOSE:  cur_byte = FRAME_CLOSE;
            default:    cur_byte = entry_reg.payload[BYTE_W*pay_idx +: BYTE_W];
        endcase
    end

    always_comb
    begin
        entry_next     = entry_reg;
        active_next    = active_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = active_reg;
            out_byte_next  = cur_byte;
            out_last_next  = at_close;
        end
        if (emit)
        begin
            pos_next = pos_reg + 1'b1;
            if (at_close)
                active_next = 1'b0;
        end
        if (pop)
        begin
            entry_next  = head_entry;
            active_next = 1'b1;
            pos_next    = POS_OPEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= POS_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> pos_reg <= POS_CLOSE)
        else $error("frame position out of range");
    a_last_is_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_byte_reg == FRAME_CLOSE)
        else $error("last flag on a byte other than the closing mark");
    a_open_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (active_reg && pos_reg == POS_OPEN))
        else $error("frame did not restart at the opening mark");
`endif
endmodule

@@ src/framed_message_generator_crc16.sv @@
// top level of the crc-16 framed message generator
//
//  channel  dir  tdata                                     tuser  tlast
//  s_axis   in   [7:0] message_command, [71:8] payload      -      -
//  m_axis   out  [7:0] frame_byte                           -      frame_last
//
// each request becomes a 14 byte frame sent one byte per cycle while the output
// is not stalled; the back end byte walk sets the rate at which requests are taken
// the front end runs the byte-serial crc and takes no new request until the
// last one is pushed; it works ahead into a two-entry queue
// reset clears the sequence counter, the queue and the output valid flag
// output backpressure stalls only the back end until the queue fills
module framed_message_generator_crc16 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fmg_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // message_command, payload_bytes
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fmg_pkg::BYTE_W-1:0]        m_axis_tdata,   // frame_byte
    output logic                              m_axis_tlast
);
    import fmg_pkg::*;

    logic        push;
    fmg_entry_t  push_entry;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    fmg_entry_t  head_entry;

    fmg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tdata[CMD_W-1:0]),
        .in_payload (s_axis_tdata[IN_DATA_W-1:CMD_W]),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    fmg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    fmg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

@@ bench/framed_message_generator_crc16_tb.sv @@
// self-checking testbench for the crc-16 framed message generator
module framed_message_generator_crc16_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fmg_pkg::*;

    localparam int FRAME_BYTES  = 14;
    localparam int CRC_BYTES    = 8;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 105;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_byte_t;

    class frame_checker;
        frame_byte_t      expected_bytes[$];
        logic [SEQ_W-1:0] next_seq;
        int               mismatches;
        int               checked;
        int               requests;
        int               wraps;

        function new();
            next_seq   = '0;
            mismatches = 0;
            checked    = 0;
            requests   = 0;
            wraps      = 0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [PAYLOAD_W-1:0] payload);
            logic [BYTE_W-1:0] frame [FRAME_BYTES];
            logic [CRC_W-1:0]  crc;
            frame_byte_t       entry;
            if (next_seq == COUNT_SKIP)
            begin
                next_seq = '0;
                wraps++;
            end
            frame[POS_OPEN] = FRAME_OPEN;
            frame[POS_SEQ]  = next_seq;
            frame[POS_CMD]  = cmd;
            for (int k = 0; k < 8; k++)
                frame[POS_PAY0 + k] = payload[8*k +: 8];
            next_seq++;
            // crc covers the counter, the command and payload bytes 0 to 5
            crc = CRC_INIT;
            for (int i = POS_SEQ; i < POS_SEQ + CRC_BYTES; i++)
            begin
                crc = crc ^ {8'h00, frame[i]};
                for (int b = 0; b < 8; b++)
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
            frame[POS_CRC_LO] = crc[7:0];
            frame[POS_CRC_HI] = crc[15:8];
            frame[POS_CLOSE]  = FRAME_CLOSE;
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                entry.data = frame[k];
                entry.last = (k == POS_CLOSE);
                expected_bytes.push_back(entry);
            end
            requests++;
        endfunction

        function void check_byte(logic [BYTE_W-1:0] data, logic last);
            frame_byte_t want;
            checked++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected byte %02h last %0b at %0t", data, last, $realtime);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("byte mismatch at %0t: expected %02h last %0b, got %02h last %0b",
                             $realtime, want.data, want.last, data, last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    frame_checker frames = new();
    bit           quiet = 1'b0;
    int           idle_cycles = 0;

    framed_message_generator_crc16 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [PAYLOAD_W-1:0] payload);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {payload, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        frames.note_request(cmd, payload);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [CMD_W-1:0]     cmd;
        logic [PAYLOAD_W-1:0] payload;
        cmd = pick_byte();
        if ($urandom_range(0, 3) == 0)
        begin
            for (int k = 0; k < 8; k++)
                payload[8*k +: 8] = pick_byte();
        end
        else
            payload = {$urandom(), $urandom()};
        send_request(cmd, payload);
    endtask

    task automatic wait_drained();
        while (frames.pending() != 0)
            @(negedge clk);
    endtask

    // output side backpressure
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            frames.check_byte(m_axis_tdata, m_axis_tlast);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("no progress for %0d cycles", IDLE_LIMIT);
        $display("framed_message_generator_crc16 test failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // field extremes and crc coverage edges
        send_request(8'h00, 64'h0000_0000_0000_0000);
        send_request(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(8'hA5, 64'h0123_4567_89AB_CDEF);
        send_request(8'h5A, 64'h5555_5555_5555_5555);
        send_request(8'hAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(8'h01, 64'hFFFF_0000_0000_0000);
        send_request(8'h80, 64'h0000_FFFF_FFFF_FFFF);
        send_request(8'h7F, 64'h8000_0000_0000_0001);
        send_request(8'h3C, 64'h3E3E_3E3E_3E3E_3E3E);
        send_request(8'h3E, 64'hFEDC_BA98_7654_3210);

        // sender holds off until the frames in flight are out
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
            if (p == 1)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d requests, checked %0d frame bytes, sequence counter wrapped %0d times",
                 frames.requests, frames.checked, frames.wraps);
        $display("mismatches %0d, bytes still expected %0d", frames.mismatches, frames.pending());
        if (frames.mismatches == 0 && frames.pending() == 0)
            $display("framed_message_generator_crc16 test passed");
        else
            $display("framed_message_generator_crc16 test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/fmg_pkg.sv
src/fmg_front.sv
src/fmg_queue.sv
src/fmg_back.sv
src/framed_message_generator_crc16.sv
bench/framed_message_generator_crc16_tb.sv
